// ===== design/ppd_pkg.sv =====
// Shared constants and types for the path point decimator.
// Used by ppd_front, ppd_queue, path_point_decimator, ppd_checker and the testbench; depends on nothing.
package ppd_pkg;

    // Default field widths, handed to the top level as parameter defaults.
    localparam int COORD_BITS_DEF = 32;
    localparam int QUAT_BITS_DEF  = 16;

    // Minimum spacing register: unsigned Q15.16, 31 bits wide.
    localparam int DIST_BITS = 31;
    localparam int DIST_SQ_BITS = 2 * DIST_BITS;
    localparam logic [DIST_BITS-1:0] MIN_DIST_RESET = 31'd65536;

    // Result queue depth; must be a power of two and at least two.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        PATH_OK        = 2'd0,
        PATH_SHORT     = 2'd1,
        PATH_TOO_CLOSE = 2'd2
    } path_status_t;

    // Write request from the front to the result queue.
    typedef struct packed {
        logic push0;
        logic push1;
    } q_push_t;

endpackage

// ===== design/path_point_decimator.sv =====
// Path point decimator: radial-distance thinning of a streamed path of poses.
// A pose is taken into the input register, decided on there, and its results go through the result queue.
// Throughput: one pose per cycle, set by the combinational distance check against the held
// pose; the input waits only while the queue has room for fewer than two results.
// Reset (rst_n, asynchronous, active low) empties the queue, ends any path
// and sets min_distance to 1.0 metre; no clearing pass is needed.
module path_point_decimator #(
    parameter int COORD_BITS = ppd_pkg::COORD_BITS_DEF,
    parameter int QUAT_BITS  = ppd_pkg::QUAT_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    // Configuration: min_distance, unsigned Q15.16.
    input  logic                          cfg_wen,
    input  logic [ppd_pkg::DIST_BITS-1:0] cfg_wdata,

    // Pose input. tdata from the lowest bit: pos_x, pos_y, pos_z, quat_x,
    // quat_y, quat_z, quat_w, zero padding. tlast: final_point.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [((3*COORD_BITS+4*QUAT_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,

    // Result output. tdata from the lowest bit: out_x, out_y, out_z, out_qx,
    // out_qy, out_qz, out_qw, zero padding. tuser: path_status.
    // tlast: end_of_path.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [((3*COORD_BITS+4*QUAT_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);

    localparam int FIELDS_W = 3 * COORD_BITS + 4 * QUAT_BITS;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    // Each queued result carries the pose fields, the status and the end flag.
    localparam int RES_W    = FIELDS_W + 3;

    ppd_pkg::q_push_t push;
    logic [RES_W-1:0] push_data0;
    logic [RES_W-1:0] push_data1;
    logic             q_space2;
    logic [RES_W-1:0] head_data;

    // The front takes a transaction into its input register, then decides
    // combinationally whether the held pose goes out, is replaced or is dropped.
    // It only works on a pose while the queue has room for two results, so a
    // stalled output never loses a result.
    ppd_front #(
        .COORD_BITS (COORD_BITS),
        .QUAT_BITS  (QUAT_BITS),
        .FIELDS_W   (FIELDS_W),
        .RES_W      (RES_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata[FIELDS_W-1:0]),
        .in_last    (s_axis_tlast),
        .q_space2   (q_space2),
        .push       (push),
        .push_data0 (push_data0),
        .push_data1 (push_data1)
    );

    // The queue decouples the decision from the output, so the input keeps
    // flowing while results wait to be taken.
    ppd_queue #(
        .RES_W      (RES_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data0 (push_data0),
        .push_data1 (push_data1),
        .space2     (q_space2),
        .head_valid (m_axis_tvalid),
        .head_ready (m_axis_tready),
        .head_data  (head_data)
    );

    assign m_axis_tdata = TDATA_W'(head_data[FIELDS_W-1:0]);
    assign m_axis_tuser = head_data[FIELDS_W+1:FIELDS_W];
    assign m_axis_tlast = head_data[FIELDS_W+2];

endmodule

// ===== design/ppd_front.sv =====
// Front end of the path point decimator: input register, held pose and the
// keep or drop decision. Depends on ppd_pkg.
module ppd_front #(
    parameter int COORD_BITS = ppd_pkg::COORD_BITS_DEF,
    parameter int QUAT_BITS  = ppd_pkg::QUAT_BITS_DEF,
    parameter int FIELDS_W   = 3 * COORD_BITS + 4 * QUAT_BITS,
    parameter int RES_W      = FIELDS_W + 3
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [ppd_pkg::DIST_BITS-1:0]  cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [FIELDS_W-1:0]            in_data,
    input  logic                           in_last,
    input  logic                           q_space2,
    output ppd_pkg::q_push_t               push,
    output logic [RES_W-1:0]               push_data0,
    output logic [RES_W-1:0]               push_data1
);

    localparam int C      = COORD_BITS;
    localparam int SQ_W   = 2 * C;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > ppd_pkg::DIST_SQ_BITS) ? SUM_W : ppd_pkg::DIST_SQ_BITS;
    localparam int QV_W   = 4 * QUAT_BITS;

    logic                            item_valid_reg;
    logic [FIELDS_W-1:0]             item_data_reg;
    logic                            item_last_reg;
    logic [ppd_pkg::DIST_SQ_BITS-1:0] min_sq_reg;

    logic [C-1:0]                    held_x_reg, held_x_next;
    logic [C-1:0]                    held_y_reg, held_y_next;
    logic [C-1:0]                    held_z_reg, held_z_next;
    logic [QV_W-1:0]                 held_q_reg, held_q_next;
    logic                            held_first_reg, held_first_next;
    logic                            started_reg, started_next;

    logic                            proc;
    logic [C-1:0]                    cur_x, cur_y, cur_z;
    logic [QV_W-1:0]                 cur_q;
    logic [C-1:0]                    adx, ady, adz;
    logic [SUM_W-1:0]                dist_sq;
    logic [CMP_W-1:0]                dist_cmp, min_cmp;
    logic                            far, near;
    logic [RES_W-1:0]                held_res, cur_res;

    // Absolute difference of two signed coordinates; always fits C bits.
    function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
        logic [C:0] d;
        d = {a[C-1], a} - {b[C-1], b};
        if (d[C])
        begin
            d = -d;
        end
        return d[C-1:0];
    endfunction

    assign proc     = item_valid_reg && q_space2;
    assign in_ready = !item_valid_reg || q_space2;

    assign cur_x = item_data_reg[C-1:0];
    assign cur_y = item_data_reg[2*C-1:C];
    assign cur_z = item_data_reg[3*C-1:2*C];
    assign cur_q = item_data_reg[FIELDS_W-1:3*C];

    assign adx = abs_diff(cur_x, held_x_reg);
    assign ady = abs_diff(cur_y, held_y_reg);
    assign adz = abs_diff(cur_z, held_z_reg);

    assign dist_sq = SUM_W'(SQ_W'(adx) * SQ_W'(adx))
                   + SUM_W'(SQ_W'(ady) * SQ_W'(ady))
                   + SUM_W'(SQ_W'(adz) * SQ_W'(adz));
    assign dist_cmp = CMP_W'(dist_sq);
    assign min_cmp  = CMP_W'(min_sq_reg);
    assign far  = dist_cmp > min_cmp;
    assign near = dist_cmp < min_cmp;

    assign held_res = {1'b0, ppd_pkg::PATH_OK, held_q_reg, held_z_reg, held_y_reg, held_x_reg};
    assign cur_res  = {1'b1, ppd_pkg::PATH_OK, item_data_reg};

    always_comb
    begin
        push            = '0;
        push_data0      = cur_res;
        push_data1      = cur_res;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        held_z_next     = held_z_reg;
        held_q_next     = held_q_reg;
        held_first_next = held_first_reg;
        started_next    = started_reg;
        if (proc)
        begin
            if (!started_reg)
            begin
                if (item_last_reg)
                begin
                    // A path of one pose only.
                    push.push0 = 1'b1;
                    push_data0 = {1'b1, ppd_pkg::PATH_SHORT, FIELDS_W'(0)};
                end
                else
                begin
                    held_x_next     = cur_x;
                    held_y_next     = cur_y;
                    held_z_next     = cur_z;
                    held_q_next     = cur_q;
                    held_first_next = 1'b1;
                    started_next    = 1'b1;
                end
            end
            else if (!item_last_reg)
            begin
                if (far)
                begin
                    push.push0      = 1'b1;
                    push_data0      = held_res;
                    held_x_next     = cur_x;
                    held_y_next     = cur_y;
                    held_z_next     = cur_z;
                    held_q_next     = cur_q;
                    held_first_next = 1'b0;
                end
            end
            else
            begin
                if (near && held_first_reg)
                begin
                    // Only the two endpoints remain and they are too close.
                    push.push0 = 1'b1;
                    push_data0 = {1'b1, ppd_pkg::PATH_TOO_CLOSE, FIELDS_W'(0)};
                end
                else if (near)
                begin
                    push.push0 = 1'b1;
                    push_data0 = cur_res;
                end
                else
                begin
                    push.push0 = 1'b1;
                    push.push1 = 1'b1;
                    push_data0 = held_res;
                    push_data1 = cur_res;
                end
                started_next    = 1'b0;
                held_first_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            started_reg    <= 1'b0;
            held_first_reg <= 1'b1;
            min_sq_reg     <= ppd_pkg::DIST_SQ_BITS'(ppd_pkg::MIN_DIST_RESET)
                            * ppd_pkg::DIST_SQ_BITS'(ppd_pkg::MIN_DIST_RESET);
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            started_reg    <= started_next;
            held_first_reg <= held_first_next;
            if (cfg_wen)
            begin
                min_sq_reg <= ppd_pkg::DIST_SQ_BITS'(cfg_wdata)
                            * ppd_pkg::DIST_SQ_BITS'(cfg_wdata);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_data_reg <= in_data;
            item_last_reg <= in_last;
        end
        held_x_reg <= held_x_next;
        held_y_reg <= held_y_next;
        held_z_reg <= held_z_next;
        held_q_reg <= held_q_next;
    end

endmodule

// ===== design/ppd_queue.sv =====
// Result queue of the path point decimator: takes up to two results per cycle
// and hands one per cycle to the output while the output is ready. Depends on ppd_pkg.
module ppd_queue #(
    parameter int RES_W = 3 * ppd_pkg::COORD_BITS_DEF + 4 * ppd_pkg::QUAT_BITS_DEF + 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ppd_pkg::q_push_t  push,
    input  logic [RES_W-1:0]  push_data0,
    input  logic [RES_W-1:0]  push_data1,
    output logic              space2,
    output logic              head_valid,
    input  logic              head_ready,
    output logic [RES_W-1:0]  head_data
);

    localparam int DEPTH = ppd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [RES_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [CNT_W-1:0] push_n;

    assign head_valid = count_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    assign space2     = count_reg <= CNT_W'(DEPTH - 2);

    always_comb
    begin
        push_n      = CNT_W'(push.push0) + CNT_W'(push.push1);
        count_next  = count_reg + push_n - CNT_W'(pop);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push.push1)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push_data1;
        end
    end

endmodule

// ===== verif/ppd_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the path point decimator: watches the configuration, pose and result channels.
// Predicts the kept poses from the accepted poses and compares each result transaction.
// Depends on ppd_pkg for the status codes and field widths.
module ppd_checker #(
    parameter int POSE_W = 160
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [ppd_pkg::DIST_BITS-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [POSE_W-1:0]             s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [POSE_W-1:0]             m_tdata,
    input  logic [1:0]                    m_tuser,
    input  logic                          m_tlast,
    input  logic                          run_done,
    output int                            errors,
    output int                            pending
);

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic [31:0]           x;
        logic [31:0]           y;
        logic [31:0]           z;
        logic [15:0]           qx;
        logic [15:0]           qy;
        logic [15:0]           qz;
        logic [15:0]           qw;
        ppd_pkg::path_status_t status;
        logic                  eop;
    } kept_pose_t;

    kept_pose_t expected_poses[$];

    logic [ppd_pkg::DIST_BITS-1:0] min_spacing;
    logic signed [31:0]            anchor_x, anchor_y, anchor_z;
    logic [63:0]                   anchor_q;
    logic                          anchor_is_first;
    logic                          path_open;
    logic                          leftover_seen;

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic forget_path();
        anchor_x = '0;
        anchor_y = '0;
        anchor_z = '0;
        anchor_q = '0;
        anchor_is_first = 1'b1;
        path_open = 1'b0;
    endtask

    task automatic queue_pose(input logic [31:0] x, y, z, input logic [63:0] q,
                              input ppd_pkg::path_status_t status, input logic eop);
        kept_pose_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.qx = q[15:0];
        p.qy = q[31:16];
        p.qz = q[47:32];
        p.qw = q[63:48];
        p.status = status;
        p.eop = eop;
        expected_poses = {expected_poses, p};
    endtask

    function automatic logic [67:0] axis_gap_sq(input logic signed [31:0] a, b);
        logic signed [33:0] d;
        logic [67:0]        m;
        d = {{2{a[31]}}, a} - {{2{b[31]}}, b};
        m = {34'b0, (d[33] ? -d : d)};
        return m * m;
    endfunction

    // Squared distance to the anchor against min_spacing squared: -1 closer, 0 equal, 1 further.
    function automatic int spacing_order(input logic signed [31:0] x, y, z);
        logic [67:0] dist_sq, lim_sq;
        dist_sq = axis_gap_sq(x, anchor_x) + axis_gap_sq(y, anchor_y)
                + axis_gap_sq(z, anchor_z);
        lim_sq = {37'b0, min_spacing} * {37'b0, min_spacing};
        if (dist_sq > lim_sq)
            return 1;
        return (dist_sq == lim_sq) ? 0 : -1;
    endfunction

    function automatic string pose_text(input kept_pose_t p);
        return $sformatf("x=%h y=%h z=%h q=%h_%h_%h_%h st=%0d eop=%b",
                         p.x, p.y, p.z, p.qw, p.qz, p.qy, p.qx, p.status, p.eop);
    endfunction

    task automatic take_pose(input logic [POSE_W-1:0] data, input logic fin);
        logic signed [31:0] px, py, pz;
        logic [63:0]        pq;
        int                 order;
        px = data[31:0];
        py = data[63:32];
        pz = data[95:64];
        pq = data[159:96];
        if (!path_open)
        begin
            if (fin)
            begin
                queue_pose('0, '0, '0, '0, ppd_pkg::PATH_SHORT, 1'b1);
                forget_path();
            end
            else
            begin
                anchor_x = px;
                anchor_y = py;
                anchor_z = pz;
                anchor_q = pq;
                anchor_is_first = 1'b1;
                path_open = 1'b1;
            end
        end
        else if (!fin)
        begin
            if (spacing_order(px, py, pz) > 0)
            begin
                queue_pose(anchor_x, anchor_y, anchor_z, anchor_q, ppd_pkg::PATH_OK, 1'b0);
                anchor_x = px;
                anchor_y = py;
                anchor_z = pz;
                anchor_q = pq;
                anchor_is_first = 1'b0;
            end
        end
        else
        begin
            order = spacing_order(px, py, pz);
            if (order < 0 && anchor_is_first)
            begin
                queue_pose('0, '0, '0, '0, ppd_pkg::PATH_TOO_CLOSE, 1'b1);
            end
            else
            begin
                // A held pose that is not the first is dropped when too near the end.
                if (order >= 0)
                    queue_pose(anchor_x, anchor_y, anchor_z, anchor_q, ppd_pkg::PATH_OK, 1'b0);
                queue_pose(px, py, pz, pq, ppd_pkg::PATH_OK, 1'b1);
            end
            forget_path();
        end
    endtask

    task automatic check_result();
        kept_pose_t got, want;
        got.x = m_tdata[31:0];
        got.y = m_tdata[63:32];
        got.z = m_tdata[95:64];
        got.qx = m_tdata[111:96];
        got.qy = m_tdata[127:112];
        got.qz = m_tdata[143:128];
        got.qw = m_tdata[159:144];
        got.status = ppd_pkg::path_status_t'(m_tuser);
        got.eop = m_tlast;
        if (expected_poses.size() == 0)
        begin
            flag_mismatch($sformatf("result transaction with nothing expected: %s",
                                    pose_text(got)));
        end
        else
        begin
            want = expected_poses.pop_front();
            if (got !== want)
                flag_mismatch($sformatf("got %s, want %s", pose_text(got), pose_text(want)));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors = 0;
            min_spacing = ppd_pkg::MIN_DIST_RESET;
            forget_path();
            expected_poses.delete();
            leftover_seen = 1'b0;
        end
        else
        begin
            if (cfg_wen)
                min_spacing = cfg_wdata;
            if (s_tvalid && s_tready)
                take_pose(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
            if (run_done && !leftover_seen && expected_poses.size() != 0)
            begin
                leftover_seen = 1'b1;
                flag_mismatch($sformatf("%0d expected results never arrived",
                                        expected_poses.size()));
            end
        end
        pending = expected_poses.size();
    end

endmodule

// ===== verif/tb_path_point_decimator.sv =====
`timescale 1ns / 100ps
// Testbench top for path_point_decimator: clock, reset, pose stimulus, spacing writes and verdict.
// Depends on ppd_pkg, the design and the ppd_checker scoreboard.
module tb_path_point_decimator;

    localparam int COORD_W = ppd_pkg::COORD_BITS_DEF;
    localparam int QUAT_W  = ppd_pkg::QUAT_BITS_DEF;
    localparam int POSE_W  = ((3*COORD_W + 4*QUAT_W + 7) / 8) * 8;

    // The cycle limit lies far beyond the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;
    // Settling time after the drain also covers poses that give no result.
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES = 10;
    localparam int POSES_PER_SETTING = 165;

    localparam logic [31:0] ONE_METRE = 32'h0001_0000;
    localparam logic [31:0] COORD_MIN = 32'h8000_0000;
    localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [63:0] QUAT_ALL_MIN = 64'h8000_8000_8000_8000;
    localparam logic [63:0] QUAT_ALL_MAX = 64'h7FFF_7FFF_7FFF_7FFF;
    localparam logic [ppd_pkg::DIST_BITS-1:0] SPACING_MAX = '1;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wen;
    logic [ppd_pkg::DIST_BITS-1:0] cfg_wdata;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [POSE_W-1:0]             s_axis_tdata;
    logic                          s_axis_tlast;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [POSE_W-1:0]             m_axis_tdata;
    logic [1:0]                    m_axis_tuser;
    logic                          m_axis_tlast;
    logic                          run_done;

    int errors;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int poses_sent;
    int cycles = 0;

    // Spacing last written, used only to size the random walk steps.
    logic [ppd_pkg::DIST_BITS-1:0] spacing;
    longint walk_x, walk_y, walk_z;

    path_point_decimator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ppd_checker #(
        .POSE_W (POSE_W)
    )
    u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tlast   (s_axis_tlast),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser),
        .m_tlast   (m_axis_tlast),
        .run_done  (run_done),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[path_point_decimator] ERROR");
            $finish;
        end
    end

    // The receiver drops tready at random, at the rate the current phase sets.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offers one pose and holds it until the transaction completes. Before the offer the
    // sender may sit idle at random, so gaps land anywhere within a path.
    task automatic send_pose(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                             input logic [63:0] q, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {q, z, y, x};
        s_axis_tlast  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        poses_sent++;
        @(negedge clk);
    endtask

    // Holds the sender off until every predicted result has been taken, then lets the
    // block settle, since the last pose may have left nothing to wait for.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Spacing writes happen only with the block idle and between paths.
    task automatic set_min_spacing(input logic [ppd_pkg::DIST_BITS-1:0] value);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        spacing    = value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic longint walk_step(input longint span);
        int unsigned hi;
        int unsigned r;
        hi = 32'(2 * span);
        r = $urandom_range(0, hi);
        return longint'(r) - span;
    endfunction

    // A random path: mostly a walk with steps of about the spacing, so poses are kept and
    // dropped in a fair mix; some paths scatter poses over the whole range, and now and
    // then a pose repeats the previous one exactly.
    task automatic send_random_path();
        int     len;
        int     r;
        int     i;
        bit     scatter;
        longint span;
        r = $urandom_range(99);
        if (r < 6)
            len = 1;
        else if (r < 15)
            len = 2;
        else
            len = $urandom_range(3, 14);
        scatter = ($urandom_range(99) < 15);
        span = longint'(spacing) + longint'(spacing) / 2 + 1;
        if (span > 64'sh7FFF_FFFF)
            span = 64'sh7FFF_FFFF;
        walk_x = $urandom;
        walk_y = $urandom;
        walk_z = $urandom;
        for (i = 0; i < len; i++)
        begin
            if (i > 0)
            begin
                if (scatter)
                begin
                    walk_x = $urandom;
                    walk_y = $urandom;
                    walk_z = $urandom;
                end
                else if ($urandom_range(9) != 0)
                begin
                    walk_x += walk_step(span);
                    walk_y += walk_step(span);
                    walk_z += walk_step(span);
                end
            end
            send_pose(walk_x[31:0], walk_y[31:0], walk_z[31:0], {$urandom, $urandom},
                      i == len - 1);
        end
    endtask

    initial
    begin
        int          phase;
        int          k;
        int          target;
        logic [31:0] v;

        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = ppd_pkg::MIN_DIST_RESET;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        run_done      = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 54;
        poses_sent    = 0;
        spacing       = ppd_pkg::MIN_DIST_RESET;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed paths at the reset spacing of one metre.
        // A path of a single pose is an error of its own.
        send_pose(32'd1, 32'd2, 32'd3, {$urandom, $urandom}, 1'b1);
        // Both endpoints in the same place: the endpoints are too close.
        send_pose(32'd5, 32'd5, 32'd5, {$urandom, $urandom}, 1'b0);
        send_pose(32'd5, 32'd5, 32'd5, {$urandom, $urandom}, 1'b1);
        // Exactly one metre: the middle pose is not kept and the end is no error.
        send_pose(32'd0, 32'd0, 32'd0, {$urandom, $urandom}, 1'b0);
        send_pose(ONE_METRE, 32'd0, 32'd0, {$urandom, $urandom}, 1'b0);
        send_pose(32'd0, ONE_METRE, 32'd0, {$urandom, $urandom}, 1'b1);
        // Opposite corners of the range; the held far pose is dropped near the end.
        send_pose(COORD_MIN, COORD_MIN, COORD_MIN, QUAT_ALL_MIN, 1'b0);
        send_pose(COORD_MAX, COORD_MAX, COORD_MAX, QUAT_ALL_MAX, 1'b0);
        send_pose(COORD_MAX - 1, COORD_MAX, COORD_MAX, {$urandom, $urandom}, 1'b0);
        send_pose(COORD_MAX - 100, COORD_MAX - 100, COORD_MAX, {$urandom, $urandom}, 1'b1);
        // Just over one metre: the middle pose is kept and then released by the end.
        send_pose(32'd0, 32'd0, 32'd0, {$urandom, $urandom}, 1'b0);
        send_pose(ONE_METRE + 1, 32'd0, 32'd0, {$urandom, $urandom}, 1'b0);
        send_pose(ONE_METRE + 1, 32'd0, 3 * ONE_METRE, {$urandom, $urandom}, 1'b1);

        // Zero spacing: nothing is ever too close, coincident poses are still not kept.
        set_min_spacing('0);
        send_pose(32'd7, 32'd7, 32'd7, {$urandom, $urandom}, 1'b0);
        send_pose(32'd7, 32'd7, 32'd7, {$urandom, $urandom}, 1'b0);
        send_pose(32'd7, 32'd7, 32'd7, {$urandom, $urandom}, 1'b1);

        // Widest spacing against the widest distances.
        set_min_spacing(SPACING_MAX);
        send_pose(COORD_MIN, COORD_MIN, COORD_MIN, {$urandom, $urandom}, 1'b0);
        send_pose(COORD_MAX, COORD_MAX, COORD_MAX, {$urandom, $urandom}, 1'b1);
        send_pose(32'd0, 32'd0, 32'd0, {$urandom, $urandom}, 1'b0);
        send_pose(32'h7FFF_FFFE, 32'd0, 32'd0, {$urandom, $urandom}, 1'b1);
        send_pose(32'd0, 32'd0, 32'd0, {$urandom, $urandom}, 1'b0);
        send_pose(32'h7FFF_FFFF, 32'd0, 32'd0, {$urandom, $urandom}, 1'b1);

        // Random paths in three idling phases, each through four spacings.
        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 54;
            end
            else if (phase == 1)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (k = 0; k < 4; k++)
            begin
                if (k == 0)
                    v = $urandom_range(1024, 200000);
                else if (k == 1)
                    v = $urandom;
                else if (k == 2)
                    v = (phase == 0) ? 32'd0 : (phase == 1) ? 32'(SPACING_MAX)
                                                            : 32'(ppd_pkg::MIN_DIST_RESET);
                else
                    v = $urandom_range(1, 4096);
                set_min_spacing(v[ppd_pkg::DIST_BITS-1:0]);
                target = poses_sent + POSES_PER_SETTING;
                while (poses_sent < target)
                    send_random_path();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        if (errors == 0)
            $display("[path_point_decimator] OK");
        else
            $display("[path_point_decimator] ERROR");
        $finish;
    end

endmodule
